// ===== design/dqim_pkg.sv =====
// Package for the dequeue/invoke matcher: field widths, status codes,
// transaction structs and the control structs shared by the table cells.
// No dependencies.
package dqim_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int THREAD_W    = 48;
    localparam int FUNC_W      = 48;
    localparam int VTABLE_W    = 48;
    localparam int REC_W       = 16;
    localparam int STATUS_W    = 3;

    localparam logic [VTABLE_W-1:0] UNMATCHABLE_VTABLE = VTABLE_W'(8'hff);

    localparam logic REQ_DEQUEUE = 1'b0;
    localparam logic REQ_INVOKE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EVICTED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MATCHED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 3'd4;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_CMP   = 2'd1;
    localparam logic [1:0] OP_MATCH = 2'd2;
    localparam logic [1:0] OP_STORE = 2'd3;

    typedef struct packed {
        logic                req_type;
        logic                invoke_start;
        logic [THREAD_W-1:0] thread_id;
        logic [FUNC_W-1:0]   func_addr;
        logic [VTABLE_W-1:0] vtable_value;
        logic [REC_W-1:0]    record_id;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REC_W-1:0]    match_id;
    } t_out_item;

    typedef struct packed {
        logic                valid;
        logic [THREAD_W-1:0] thread;
        logic [FUNC_W-1:0]   func;
        logic [REC_W-1:0]    record;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        logic       evict;
    } t_cell_ctl;

    typedef struct packed {
        logic             found;
        logic [REC_W-1:0] record;
    } t_chain;

endpackage

// ===== design/dqim_cell.sv =====
// One slot of the age-ordered pending table: holds an entry, compares it
// against the current event and shifts toward the oldest end on removal.
// Depends on dqim_pkg.
module dqim_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dqim_pkg::t_cell_ctl i_ctl,
    input  dqim_pkg::t_entry   i_new,
    input  dqim_pkg::t_entry   i_upper,
    input  logic               i_lower_valid,
    input  logic               i_any_hit,
    input  dqim_pkg::t_chain   i_chain,
    output dqim_pkg::t_chain   o_chain,
    output dqim_pkg::t_entry   o_entry
);
    import dqim_pkg::*;

    logic                r_valid;
    logic                n_valid;
    logic [THREAD_W-1:0] r_thread;
    logic [THREAD_W-1:0] n_thread;
    logic [FUNC_W-1:0]   r_func;
    logic [FUNC_W-1:0]   n_func;
    logic [REC_W-1:0]    r_record;
    logic [REC_W-1:0]    n_record;
    logic                r_hit;
    logic                n_hit;
    logic                w_hit;

    assign w_hit          = r_hit & r_valid;
    assign o_chain.found  = i_chain.found | w_hit;
    assign o_chain.record = (w_hit && !i_chain.found) ? r_record : i_chain.record;

    assign o_entry.valid  = r_valid;
    assign o_entry.thread = r_thread;
    assign o_entry.func   = r_func;
    assign o_entry.record = r_record;

    always_comb begin
        n_valid  = r_valid;
        n_thread = r_thread;
        n_func   = r_func;
        n_record = r_record;
        n_hit    = r_hit;
        case (i_ctl.op)
            OP_CMP: begin
                n_hit = r_valid && (r_thread == i_new.thread) && (r_func == i_new.func);
            end
            OP_MATCH: begin
                if (i_any_hit && !i_chain.found) begin
                    n_valid  = i_upper.valid;
                    n_thread = i_upper.thread;
                    n_func   = i_upper.func;
                    n_record = i_upper.record;
                end
            end
            OP_STORE: begin
                if (i_ctl.evict) begin
                    n_valid  = i_upper.valid;
                    n_thread = i_upper.thread;
                    n_func   = i_upper.func;
                    n_record = i_upper.record;
                end else if (!r_valid && i_lower_valid) begin
                    n_valid  = 1'b1;
                    n_thread = i_new.thread;
                    n_func   = i_new.func;
                    n_record = i_new.record;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thread <= n_thread;
        r_func   <= n_func;
        r_record <= n_record;
        r_hit    <= n_hit;
    end

endmodule

// ===== design/dequeue_invoke_matcher.sv =====
// Top level of the dequeue/invoke matcher: event sequencing, the chain of
// table cells and the output register.
// Depends on dqim_pkg and dqim_cell.
//
//   Channel  Signals                            Payload
//   input    i_in_valid / o_in_stall            i_in_item  (t_in_item)
//   output   o_out_valid / i_out_stall          o_out_item (t_out_item)
//
// Each transaction passes three steps: capture, a registered compare in every
// cell, then the update with its chained newest-first removal.
// The next input transaction is taken only in the idle state, after the result is written.
// Reset is synchronous and active low and empties the table.
// A stalled output holds the update step until the output register frees.
module dequeue_invoke_matcher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dqim_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dqim_pkg::t_out_item o_out_item
);
    import dqim_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_in_item         r_item;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        w_result;
    t_cell_ctl        w_ctl;
    t_entry           w_new;
    t_entry           w_top_upper;
    t_entry           w_entry [TABLE_DEPTH];
    t_chain           w_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_valid;
    logic             w_accept;
    logic             w_out_free;
    logic             w_fire;
    logic             w_storable;
    logic             w_lookup;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fire      = (r_state == S_APPLY) && w_out_free;
    assign w_storable  = (r_item.req_type == REQ_DEQUEUE) &&
                         (r_item.vtable_value < UNMATCHABLE_VTABLE);
    assign w_lookup    = (r_item.req_type == REQ_INVOKE) && r_item.invoke_start;

    assign w_new.valid  = 1'b1;
    assign w_new.thread = r_item.thread_id;
    assign w_new.func   = r_item.func_addr;
    assign w_new.record = r_item.record_id;

    assign w_top_upper.valid  = (w_ctl.op == OP_STORE);
    assign w_top_upper.thread = r_item.thread_id;
    assign w_top_upper.func   = r_item.func_addr;
    assign w_top_upper.record = r_item.record_id;

    assign w_chain[TABLE_DEPTH].found  = 1'b0;
    assign w_chain[TABLE_DEPTH].record = '0;

    always_comb begin
        w_ctl.evict = w_valid[TABLE_DEPTH-1];
        w_ctl.op    = OP_NONE;
        if (r_state == S_CMP) begin
            w_ctl.op = OP_CMP;
        end else if (w_fire && w_storable) begin
            w_ctl.op = OP_STORE;
        end else if (w_fire && w_lookup) begin
            w_ctl.op = OP_MATCH;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            t_entry w_upper;
            logic   w_lower_valid;

            if (gi == TABLE_DEPTH - 1) begin : g_top
                assign w_upper = w_top_upper;
            end else begin : g_mid
                assign w_upper = w_entry[gi+1];
            end

            if (gi == 0) begin : g_bottom
                assign w_lower_valid = 1'b1;
            end else begin : g_rest
                assign w_lower_valid = w_entry[gi-1].valid;
            end

            dqim_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_new         (w_new),
                .i_upper       (w_upper),
                .i_lower_valid (w_lower_valid),
                .i_any_hit     (w_chain[0].found),
                .i_chain       (w_chain[gi+1]),
                .o_chain       (w_chain[gi]),
                .o_entry       (w_entry[gi])
            );

            assign w_valid[gi] = w_entry[gi].valid;
        end
    endgenerate

    always_comb begin
        w_result.status   = STAT_IGNORED;
        w_result.match_id = '0;
        if (w_storable) begin
            if (w_valid[TABLE_DEPTH-1]) begin
                w_result.status   = STAT_EVICTED;
                w_result.match_id = w_entry[0].record;
            end else begin
                w_result.status = STAT_STORED;
            end
        end else if (w_lookup) begin
            if (w_chain[0].found) begin
                w_result.status   = STAT_MATCHED;
                w_result.match_id = w_chain[0].record;
            end else begin
                w_result.status = STAT_NOMATCH;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The occupied slots always form one run starting at the oldest slot.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_valid} + {{TABLE_DEPTH{1'b0}}, 1'b1}) ||
        (w_valid == {TABLE_DEPTH{1'b1}}))
        else $error("Occupied table slots are not contiguous.");

    // A successful match removes exactly one entry.
    a_match_removes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_MATCH && w_chain[0].found) |=>
        ($countones(w_valid) == $past($countones(w_valid)) - 1))
        else $error("A match did not remove exactly one entry.");

    // A store adds one entry unless the table was full, where it stays full.
    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_STORE) |=>
        (($countones(w_valid) == $past($countones(w_valid)) + 1) ||
         ($past(w_valid[TABLE_DEPTH-1]) && w_valid[TABLE_DEPTH-1])))
        else $error("A store did not update the occupancy correctly.");

    // A failed lookup leaves the table untouched.
    a_nomatch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_lookup && !w_chain[0].found) |=> $stable(w_valid))
        else $error("A lookup without a hit changed the table.");

endmodule
